### rtl/tsgoc_pkg.sv
`timescale 1ns / 1ps

package tsgoc_pkg;

	// Field widths
	localparam int VAL_W   = 48;
	localparam int WORD_W  = 32;
	localparam int K_W     = 17;
	localparam int NUM_W   = 64;

	// Divider: quotient bits resolved per stage and stage count
	localparam int DIV_BITS   = 4;
	localparam int DIV_STAGES = VAL_W / DIV_BITS;

	// Command codes
	localparam logic [1:0] CMD_ERR = 2'd0;
	localparam logic [1:0] CMD_FB  = 2'd1;
	localparam logic [1:0] CMD_OFB = 2'd2;
	localparam logic [1:0] CMD_WR  = 2'd3;

	// Table code that selects no table
	localparam logic [1:0] TBL_BAD = 2'd3;

	// Segment codes
	localparam logic [1:0] SEG_NONE = 2'd0;
	localparam logic [1:0] SEG_ONE  = 2'd1;
	localparam logic [1:0] SEG_TWO  = 2'd2;

	// Register indexes
	localparam logic [1:0] REG_THR_LO = 2'd0;
	localparam logic [1:0] REG_THR_HI = 2'd1;
	localparam logic [1:0] REG_SCALE  = 2'd2;

	// Gain limits, gain scaled by 100000
	localparam logic [K_W-1:0]    K_UNITY = 17'd100000;
	localparam logic [WORD_W-1:0] K_MIN   = 32'd80000;
	localparam logic [WORD_W-1:0] K_MAX   = 32'd120000;

	// Saturation bounds, as magnitudes
	localparam logic [NUM_W-1:0] POS_MAX_MAG = 64'h0000_7FFF_FFFF_FFFF;
	localparam logic [NUM_W-1:0] NEG_MIN_MAG = 64'h0000_8000_0000_0000;
	localparam logic [VAL_W-1:0] POS_MAX48   = 48'h7FFF_FFFF_FFFF;
	localparam logic [VAL_W-1:0] NEG_MIN48   = 48'h8000_0000_0000;

	// What happens to a word on its way through
	typedef enum logic [1:0] {
		KIND_ERR,
		KIND_FB,
		KIND_PASS,
		KIND_WR
	} kind_t;

	typedef struct packed {
		kind_t            kind;
		logic [1:0]       seg;
		logic             dflt;
		logic             neg;
		logic [VAL_W-1:0] pval;
	} meta_t;

	typedef struct packed {
		logic [K_W-1:0]   rem;
		logic [VAL_W-1:0] w;
		logic [K_W-1:0]   dvs;
		meta_t            meta;
	} div_t;

endpackage

### rtl/tsgoc_if.sv
`timescale 1ns / 1ps

// Input word channel
interface tsgoc_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [2:0]  channel;
	logic [47:0] value;
	logic [1:0]  table_select;
	logic        segment_select;
	logic [31:0] gain_word;
	logic [31:0] offset_word;

	modport source(output valid, cmd, channel, value, table_select, segment_select,
		gain_word, offset_word, input ready);
	modport sink(input valid, cmd, channel, value, table_select, segment_select,
		gain_word, offset_word, output ready);
endinterface

// Result word channel
interface tsgoc_out_if;
	logic        valid;
	logic        ready;
	logic [47:0] corrected;
	logic [1:0]  segment_used;
	logic        coefficients_defaulted;
	logic        saturated;

	modport source(output valid, corrected, segment_used, coefficients_defaulted,
		saturated, input ready);
	modport sink(input valid, corrected, segment_used, coefficients_defaulted,
		saturated, output ready);
endinterface

### rtl/tsgoc_coef_store.sv
`timescale 1ns / 1ps

module tsgoc_coef_store #(
	parameter int DEPTH = 48,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [63:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	input  logic          rd_ok,
	output logic [63:0]   rdata
);

	logic [63:0]      mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [63:0]      rdata_q;
	logic             rok_q;

	// Write array and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	// Track written entries; unwritten ones read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rok_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (re) begin
				rok_q <= rd_ok && vld_q[raddr];
			end
		end
	end

	assign rdata = rok_q ? rdata_q : 64'd0;

endmodule

### rtl/tsgoc_div_stage.sv
`timescale 1ns / 1ps

module tsgoc_div_stage import tsgoc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  div_t in_data,
	output logic in_ready,
	output logic out_valid,
	output div_t out_data,
	input  logic out_ready
);

	logic v_q;
	div_t d_q;
	div_t nxt;

	assign in_ready  = !v_q || out_ready;
	assign out_valid = v_q;
	assign out_data  = d_q;

	// Resolve a few quotient bits by restoring subtraction
	always_comb begin
		logic [K_W:0] r;
		logic         ge;
		nxt = in_data;
		for (int j = 0; j < DIV_BITS; j++) begin
			r  = {nxt.rem, nxt.w[VAL_W-1]};
			ge = r >= {1'b0, nxt.dvs};
			nxt.rem = ge ? K_W'(r - {1'b0, nxt.dvs}) : r[K_W-1:0];
			nxt.w   = {nxt.w[VAL_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			d_q <= nxt;
		end
	end

endmodule

### rtl/two_segment_gain_offset_calibration.sv
`timescale 1ns / 1ps
// Throughput: one word per cycle unless back-pressure from dout.ready stalls
// the pipe; the gain divider is a 12-stage pipeline resolving 4 quotient bits
// per stage, and every stage stalls independently.
// Reset clears all valid bits, the thresholds to zero, the output scale to 1.0
// and marks every coefficient entry unwritten, so it reads as unity gain.
module two_segment_gain_offset_calibration import tsgoc_pkg::*; #(
	parameter int CHANNELS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	tsgoc_in_if.sink    din,
	tsgoc_out_if.source dout,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [47:0] cfg_data
);

	localparam int DEPTH = CHANNELS * 6;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// Configuration registers
	logic [VAL_W-1:0]  thr_lo_q;
	logic [VAL_W-1:0]  thr_hi_q;
	logic [WORD_W-1:0] scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_lo_q <= '0;
			thr_hi_q <= '0;
			scale_q  <= 32'd65536;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_THR_LO: thr_lo_q <= cfg_data;
				REG_THR_HI: thr_hi_q <= cfg_data;
				REG_SCALE:  scale_q  <= cfg_data[WORD_W-1:0];
				default: ;
			endcase
		end
	end

	// Stage enables, back to front
	logic en1, en2, en3, en4, en5, en18, en19, en20, en_out;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s18, v_s19, v_s20, out_v_q;
	logic [DIV_STAGES:0] dv;
	logic [DIV_STAGES:0] drdy;
	div_t                div_d [DIV_STAGES+1];

	assign en_out = !out_v_q || dout.ready;
	assign en20   = !v_s20 || en_out;
	assign en19   = !v_s19 || en20;
	assign en18   = !v_s18 || en19;
	assign drdy[DIV_STAGES] = en18;
	assign en5    = !v_s5 || drdy[0];
	assign en4    = !v_s4 || en5;
	assign en3    = !v_s3 || en4;
	assign en2    = !v_s2 || en3;
	assign en1    = !v_s1 || en2;
	assign din.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; v_s5 <= 1'b0;
			v_s18 <= 1'b0; v_s19 <= 1'b0; v_s20 <= 1'b0; out_v_q <= 1'b0;
		end else begin
			if (en1)  v_s1 <= din.valid;
			if (en2)  v_s2 <= v_s1;
			if (en3)  v_s3 <= v_s2;
			if (en4)  v_s4 <= v_s3;
			if (en5)  v_s5 <= v_s4;
			if (en18) v_s18 <= dv[DIV_STAGES];
			if (en19) v_s19 <= v_s18;
			if (en20) v_s20 <= v_s19;
			if (en_out) out_v_q <= v_s20;
		end
	end

	// Stage 1: capture word and classify segment
	logic [1:0]        cmd_s1, tsel_s1, seg_s1;
	logic [2:0]        chan_s1;
	logic [VAL_W-1:0]  val_s1;
	logic              ssel_s1, cin_s1;
	logic [WORD_W-1:0] kw_s1, bw_s1;
	logic              below_lo, within_hi;

	assign below_lo  = $signed(din.value) < $signed(thr_lo_q);
	assign within_hi = $signed(din.value) <= $signed(thr_hi_q);

	always_ff @(posedge clk) begin
		if (en1) begin
			cmd_s1  <= din.cmd;
			chan_s1 <= din.channel;
			val_s1  <= din.value;
			tsel_s1 <= din.table_select;
			ssel_s1 <= din.segment_select;
			kw_s1   <= din.gain_word;
			bw_s1   <= din.offset_word;
			cin_s1  <= 32'(din.channel) < CHANNELS;
			seg_s1  <= below_lo ? SEG_ONE : (within_hi ? SEG_TWO : SEG_NONE);
		end
	end

	// Coefficient store access
	logic [5:0]    widx, ridx;
	logic          st_we;
	logic [63:0]   entry;
	logic          seg_bit;

	assign seg_bit = seg_s1 == SEG_TWO;
	assign widx  = ({3'd0, chan_s1} * 6'd3 + {4'd0, tsel_s1}) * 6'd2 + {5'd0, ssel_s1};
	assign ridx  = ({3'd0, chan_s1} * 6'd3 + {4'd0, cmd_s1}) * 6'd2 + {5'd0, seg_bit};
	assign st_we = v_s1 && en2 && cmd_s1 == CMD_WR && tsel_s1 != TBL_BAD && cin_s1;

	tsgoc_coef_store #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_store (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (st_we),
		.waddr (AW'(widx)),
		.wdata ({bw_s1, kw_s1}),
		.re    (en2),
		.raddr (AW'(ridx)),
		.rd_ok (cin_s1 && seg_s1 != SEG_NONE && cmd_s1 != CMD_WR),
		.rdata (entry)
	);

	// Stage 2: carry word beside the coefficient read
	kind_t            kind_s2;
	logic [1:0]       seg_s2;
	logic [VAL_W-1:0] val_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			val_s2 <= val_s1;
			seg_s2 <= seg_s1;
			if (cmd_s1 == CMD_WR) begin
				kind_s2 <= KIND_WR;
			end else if (cmd_s1 == CMD_ERR) begin
				kind_s2 <= KIND_ERR;
			end else if (seg_s1 == SEG_NONE) begin
				kind_s2 <= KIND_PASS;
			end else begin
				kind_s2 <= KIND_FB;
			end
		end
	end

	// Stage 3: check gain, take magnitudes, pick multiplier operand
	logic [K_W-1:0]    kc;
	logic [WORD_W-1:0] bc;
	logic              dflt_c, vn_c, klt_c;
	logic [VAL_W-1:0]  vm_c;
	logic [K_W-1:0]    dk_c;
	logic [34:0]       b10_c;

	always_comb begin
		kc     = K_UNITY;
		bc     = '0;
		dflt_c = 1'b0;
		if (seg_s2 != SEG_NONE) begin
			if (entry[31:0] > K_MAX || entry[31:0] < K_MIN) begin
				dflt_c = 1'b1;
			end else begin
				kc = entry[K_W-1:0];
				bc = entry[63:32];
			end
		end
		vn_c  = val_s2[VAL_W-1];
		vm_c  = vn_c ? (~val_s2 + 48'd1) : val_s2;
		klt_c = kc < K_UNITY;
		dk_c  = klt_c ? (K_UNITY - kc) : (kc - K_UNITY);
		b10_c = {1'b0, bc[30:0], 3'd0} + {3'd0, bc[30:0], 1'b0};
	end

	logic [VAL_W-1:0] vm_s3;
	logic [K_W-1:0]   mop_s3, dvs_s3;
	logic             an_s3, bn_s3;
	logic [50:0]      bm_s3;
	meta_t            meta_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			vm_s3  <= vm_c;
			mop_s3 <= (kind_s2 == KIND_ERR) ? dk_c : kc;
			an_s3  <= (kind_s2 == KIND_ERR) ? (vn_c ^ klt_c) : vn_c;
			dvs_s3 <= (kind_s2 == KIND_ERR) ? kc : K_UNITY;
			bm_s3  <= {b10_c, 16'd0};
			bn_s3  <= bc[31];
			meta_s3.kind <= kind_s2;
			meta_s3.seg  <= seg_s2;
			meta_s3.dflt <= dflt_c;
			meta_s3.neg  <= 1'b0;
			meta_s3.pval <= val_s2;
		end
	end

	// Stage 4: scale magnitude by gain term
	logic [NUM_W-1:0] am_s4;
	logic             an_s4, bn_s4;
	logic [50:0]      bm_s4;
	logic [K_W-1:0]   dvs_s4;
	meta_t            meta_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			am_s4   <= NUM_W'(vm_s3 * mop_s3);
			an_s4   <= an_s3;
			bm_s4   <= bm_s3;
			bn_s4   <= bn_s3;
			dvs_s4  <= dvs_s3;
			meta_s4 <= meta_s3;
		end
	end

	// Stage 5: sign-magnitude add of offset, seed divider
	logic [NUM_W-1:0] bm64, nm_c;
	logic             nn_c;
	div_t             div_c, div_s5;

	always_comb begin
		bm64 = NUM_W'(bm_s4);
		if (an_s4 == bn_s4) begin
			nm_c = am_s4 + bm64;
			nn_c = an_s4;
		end else if (am_s4 >= bm64) begin
			nm_c = am_s4 - bm64;
			nn_c = an_s4;
		end else begin
			nm_c = bm64 - am_s4;
			nn_c = bn_s4;
		end
		div_c          = '0;
		div_c.rem      = {1'b0, nm_c[NUM_W-1:VAL_W]};
		div_c.w        = nm_c[VAL_W-1:0];
		div_c.dvs      = dvs_s4;
		div_c.meta     = meta_s4;
		div_c.meta.neg = nn_c;
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			div_s5 <= div_c;
		end
	end

	// Divider pipeline
	assign dv[0]    = v_s5;
	assign div_d[0] = div_s5;

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		tsgoc_div_stage u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (dv[g]),
			.in_data  (div_d[g]),
			.in_ready (drdy[g]),
			.out_valid(dv[g+1]),
			.out_data (div_d[g+1]),
			.out_ready(drdy[g+1])
		);
	end

	// Stage 18: round quotient to nearest
	div_t             dq_in;
	logic             up_c;
	logic [VAL_W:0]   dq_s18;
	meta_t            meta_s18;

	assign dq_in = div_d[DIV_STAGES];
	assign up_c  = dq_in.rem >= (dq_in.dvs - (dq_in.dvs >> 1));

	always_ff @(posedge clk) begin
		if (en18) begin
			dq_s18   <= {1'b0, dq_in.w} + {{VAL_W{1'b0}}, up_c};
			meta_s18 <= dq_in.meta;
		end
	end

	// Stage 19: apply output scale halves
	logic [NUM_W-1:0] p1_s19, p2_s19;
	logic [VAL_W:0]   dq_s19;
	meta_t            meta_s19;

	always_ff @(posedge clk) begin
		if (en19) begin
			p1_s19   <= NUM_W'(dq_s18 * scale_q[31:16]);
			p2_s19   <= NUM_W'(dq_s18 * scale_q[15:0]);
			dq_s19   <= dq_s18;
			meta_s19 <= meta_s18;
		end
	end

	// Stage 20: merge scaled parts with rounding
	logic [NUM_W-1:0] res_s20;
	meta_t            meta_s20;

	always_ff @(posedge clk) begin
		if (en20) begin
			if (meta_s19.kind == KIND_ERR) begin
				res_s20 <= p1_s19 + {16'd0, p2_s19[NUM_W-1:16]} + {63'd0, p2_s19[15]};
			end else begin
				res_s20 <= NUM_W'(dq_s19);
			end
			meta_s20 <= meta_s19;
		end
	end

	// Output stage: saturate and restore sign; pass words keep their value, writes give zero
	logic [VAL_W-1:0] corr_c;
	logic [1:0]       seg_c;
	logic             dfl_c, sat_c;

	always_comb begin
		corr_c = '0;
		seg_c  = SEG_NONE;
		dfl_c  = 1'b0;
		sat_c  = 1'b0;
		case (meta_s20.kind)
			KIND_WR: ;
			KIND_PASS: corr_c = meta_s20.pval;
			default: begin
				seg_c = meta_s20.seg;
				dfl_c = meta_s20.dflt;
				if (!meta_s20.neg && res_s20 > POS_MAX_MAG) begin
					corr_c = POS_MAX48;
					sat_c  = 1'b1;
				end else if (meta_s20.neg && res_s20 > NEG_MIN_MAG) begin
					corr_c = NEG_MIN48;
					sat_c  = 1'b1;
				end else if (meta_s20.neg) begin
					corr_c = ~res_s20[VAL_W-1:0] + 48'd1;
				end else begin
					corr_c = res_s20[VAL_W-1:0];
				end
			end
		endcase
	end

	logic [VAL_W-1:0] corr_q;
	logic [1:0]       seg_q;
	logic             dfl_q, sat_q;

	always_ff @(posedge clk) begin
		if (en_out) begin
			corr_q <= corr_c;
			seg_q  <= seg_c;
			dfl_q  <= dfl_c;
			sat_q  <= sat_c;
		end
	end

	assign dout.valid                  = out_v_q;
	assign dout.corrected              = corr_q;
	assign dout.segment_used           = seg_q;
	assign dout.coefficients_defaulted = dfl_q;
	assign dout.saturated              = sat_q;

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb import tsgoc_pkg::*;;

	localparam int NCH = 8;
	localparam logic [63:0] MASK48 = 64'hFFFF_FFFF_FFFF;
	localparam logic [63:0] BIT47 = 64'h8000_0000_0000;
	localparam logic [63:0] UNITY = 64'd100000;
	localparam int DRAIN = 30;

	typedef struct packed {
		logic [47:0] corrected;
		logic [1:0]  segment_used;
		logic        coefficients_defaulted;
		logic        saturated;
	} result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [47:0] cfg_data = '0;

	tsgoc_in_if din();
	tsgoc_out_if dout();

	two_segment_gain_offset_calibration #(.CHANNELS(NCH)) uut (
		.clk(clk), .arst_n(arst_n), .din(din.sink), .dout(dout.source),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Model copy of the block state
	logic [63:0] coef_store [NCH*6];
	logic [47:0] thr_lo, thr_hi;
	logic [31:0] out_scale;

	result_t expected_q [$];
	int mismatches = 0;
	bit idle_on = 1'b1;

	always #6 clk = ~clk;

	function automatic logic [63:0] round_div(logic [63:0] n, logic [63:0] d);
		return n / d + (((n % d) >= d - d / 2) ? 64'd1 : 64'd0);
	endfunction

	function automatic logic [63:0] sm_add(logic [63:0] am, logic an, logic [63:0] bm,
		logic bn, output logic rn);
		if (an == bn) begin
			rn = an;
			return am + bm;
		end
		if (am >= bm) begin
			rn = an;
			return am - bm;
		end
		rn = bn;
		return bm - am;
	endfunction

	function automatic logic [47:0] clip48(logic [63:0] m, logic neg, output logic sat);
		sat = 1'b0;
		if (!neg && m > 64'h7FFF_FFFF_FFFF) begin
			sat = 1'b1;
			return POS_MAX48;
		end
		if (neg && m > BIT47) begin
			sat = 1'b1;
			return NEG_MIN48;
		end
		if (m == 0) return '0;
		return neg ? 48'((MASK48 + 64'd1) - m) : m[47:0];
	endfunction

	// Compute the expected result of one word; apply coefficient writes
	function automatic result_t calibrate_word(logic [1:0] cmd, logic [2:0] ch,
		logic [47:0] val, logic [1:0] tsel, logic ssel, logic [31:0] kw, logic [31:0] bw);
		result_t r;
		logic [63:0] vb, lo, hi, entry, k, b, vm, bm, am, nm, res, dk, d;
		logic [1:0] seg;
		logic vn, bn, an, nn, sat, dflt;
		r = '0;
		dflt = 1'b0;
		if (cmd == CMD_WR) begin
			if (tsel != TBL_BAD && ch < NCH)
				coef_store[(ch * 3 + tsel) * 2 + ssel] = {bw, kw};
			return r;
		end
		vb = {16'd0, val} ^ BIT47;
		lo = {16'd0, thr_lo} ^ BIT47;
		hi = {16'd0, thr_hi} ^ BIT47;
		if (vb < lo) seg = SEG_ONE;
		else if (vb <= hi) seg = SEG_TWO;
		else seg = SEG_NONE;
		if (seg == SEG_NONE) begin
			if (cmd != CMD_ERR) begin
				r.corrected = val;
				return r;
			end
			k = UNITY;
			b = 0;
		end else begin
			entry = coef_store[(ch * 3 + cmd) * 2 + (seg - 1)];
			k = {32'd0, entry[31:0]};
			b = {32'd0, entry[63:32]};
			if (k > 64'd120000 || k < 64'd80000) begin
				k = UNITY;
				b = 0;
				dflt = 1'b1;
			end
		end
		vn = val[47];
		vm = vn ? (MASK48 + 64'd1) - {16'd0, val} : {16'd0, val};
		bm = {33'd0, b[30:0]} * 64'd655360;
		bn = b[31];
		if (cmd == CMD_ERR) begin
			dk = (k >= UNITY) ? k - UNITY : UNITY - k;
			am = vm * dk;
			an = vn != (k < UNITY);
			nm = sm_add(am, an, bm, bn, nn);
			d = round_div(nm, k);
			res = d * {48'd0, out_scale[31:16]}
				+ round_div(d * {48'd0, out_scale[15:0]}, 64'd65536);
		end else begin
			am = vm * k;
			nm = sm_add(am, vn, bm, bn, nn);
			res = round_div(nm, UNITY);
		end
		r.corrected = clip48(res, nn, sat);
		r.segment_used = seg;
		r.coefficients_defaulted = dflt;
		r.saturated = sat;
		return r;
	endfunction

	function automatic int gap_len();
		int p;
		if (!idle_on) return 0;
		p = $urandom_range(99);
		if (p < 60) return 0;
		if (p < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Drive one word and hold it until the block takes it
	task automatic send_word(logic [1:0] cmd, logic [2:0] ch, logic [47:0] val,
		logic [1:0] tsel, logic ssel, logic [31:0] kw, logic [31:0] bw);
		int g;
		@(negedge clk);
		din.valid <= 1'b1;
		din.cmd <= cmd;
		din.channel <= ch;
		din.value <= val;
		din.table_select <= tsel;
		din.segment_select <= ssel;
		din.gain_word <= kw;
		din.offset_word <= bw;
		do @(posedge clk); while (!din.ready);
		expected_q.push_back(calibrate_word(cmd, ch, val, tsel, ssel, kw, bw));
		g = gap_len();
		if (g > 0) begin
			@(negedge clk);
			din.valid <= 1'b0;
			repeat (g - 1) @(negedge clk);
		end
	endtask

	// Wait for the pipe to drain, then write one register
	task automatic write_reg(logic [1:0] idx, logic [47:0] data);
		@(negedge clk);
		din.valid <= 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
		repeat (DRAIN) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_THR_LO: thr_lo = data;
			REG_THR_HI: thr_hi = data;
			REG_SCALE: out_scale = data[31:0];
			default: ;
		endcase
	endtask

	function automatic logic [47:0] rand48();
		return 48'({$urandom(), $urandom()});
	endfunction

	function automatic logic [31:0] rand_gain();
		int p;
		p = $urandom_range(9);
		if (p < 7) return $urandom_range(80000, 120000);
		if (p < 8) return $urandom_range(79990, 80010) + (($urandom_range(1)) ? 40000 : 0);
		return $urandom();
	endfunction

	function automatic logic [31:0] rand_offset();
		if ($urandom_range(3) == 0) return $urandom();
		return {1'($urandom_range(1)), 31'($urandom_range(0, 2000000))};
	endfunction

	// Values near a threshold, near the extremes, or anywhere
	function automatic logic [47:0] rand_value();
		int p;
		p = $urandom_range(9);
		if (p < 3) return thr_lo + 48'($signed($urandom_range(0, 8)) - 4);
		if (p < 5) return thr_hi + 48'($signed($urandom_range(0, 8)) - 4);
		if (p < 6) return ($urandom_range(1) ? POS_MAX48 : NEG_MIN48) + 48'($urandom_range(3)) - 48'd1;
		if (p < 8) return 48'($signed($urandom()) >>> $urandom_range(0, 20));
		return rand48();
	endfunction

	task automatic random_words(int n);
		logic [1:0] cmd;
		repeat (n) begin
			cmd = ($urandom_range(9) < 2) ? CMD_WR : 2'($urandom_range(2));
			send_word(cmd, 3'($urandom()), rand_value(), 2'($urandom()), 1'($urandom()),
				rand_gain(), rand_offset());
		end
	endtask

	// Load every table entry with a random gain and offset
	task automatic fill_tables();
		for (int c = 0; c < NCH; c++)
			for (int t = 0; t < 3; t++)
				for (int s = 0; s < 2; s++)
					send_word(CMD_WR, 3'(c), rand48(), 2'(t), 1'(s), rand_gain(),
						rand_offset());
	endtask

	task automatic test_directed();
		// Unwritten store reads as unity, then gain edges and offsets
		write_reg(REG_THR_LO, 48'h0000_0001_0000);
		write_reg(REG_THR_HI, 48'h0010_0000_0000);
		send_word(CMD_FB, 0, NEG_MIN48, 0, 0, 0, 0);
		send_word(CMD_ERR, 0, 48'h0000_0002_0000, 0, 0, 0, 0);
		send_word(CMD_WR, 0, 0, 0, 0, 32'd80000, 32'h8000_1234);
		send_word(CMD_WR, 0, 0, 0, 1, 32'd120000, 32'h7FFF_FFFF);
		send_word(CMD_WR, 0, 0, 1, 0, 32'd79999, 32'h0000_0010);
		send_word(CMD_WR, 0, 0, 1, 1, 32'd120001, 32'h0000_0010);
		send_word(CMD_WR, 0, 0, 2, 0, 32'd100000, 32'hFFFF_FFFF);
		send_word(CMD_WR, 0, 0, 2, 1, 32'hFFFF_FFFF, 32'h0);
		send_word(CMD_WR, 0, 0, TBL_BAD, 1, 32'd90000, 32'h5);
		for (int cm = 0; cm < 3; cm++) begin
			send_word(2'(cm), 0, NEG_MIN48, 0, 0, 0, 0);
			send_word(2'(cm), 0, 48'hFFFF_FFFF_FFFF, 0, 0, 0, 0);
			send_word(2'(cm), 0, 48'h0000_0001_0000, 0, 0, 0, 0);
			send_word(2'(cm), 0, 48'h0010_0000_0000, 0, 0, 0, 0);
			send_word(2'(cm), 0, POS_MAX48, 0, 0, 0, 0);
		end
	endtask

	task automatic test_scales();
		logic [31:0] scales [4] = '{32'd0, 32'hFFFF_FFFF, 32'd65536, 32'h0003_8000};
		foreach (scales[i]) begin
			write_reg(REG_SCALE, 48'(scales[i]));
			random_words(100);
		end
	endtask

	task automatic test_thresholds();
		// Full range, empty range, inverted, narrow, reset values
		logic [47:0] los [5] = '{NEG_MIN48, POS_MAX48, 48'h0001_0000_0000, 48'hFFFF_FFF0_0000, 48'd0};
		logic [47:0] his [5] = '{POS_MAX48, NEG_MIN48, 48'hFFFF_0000_0000, 48'h0000_0010_0000, 48'd0};
		for (int i = 0; i < 5; i++) begin
			write_reg(REG_THR_LO, los[i]);
			write_reg(REG_THR_HI, his[i]);
			idle_on = (i != 2);
			random_words(120);
		end
		idle_on = 1'b1;
	endtask

	task automatic test_random();
		logic [47:0] a, b;
		for (int ph = 0; ph < 4; ph++) begin
			a = rand48();
			b = rand48();
			write_reg(REG_THR_LO, ($signed(a) < $signed(b)) ? a : b);
			write_reg(REG_THR_HI, ($signed(a) < $signed(b)) ? b : a);
			write_reg(REG_SCALE, 48'($urandom()));
			fill_tables();
			random_words(100);
		end
	endtask

	// Randomize backpressure on the result side
	always @(negedge clk) begin
		if (!arst_n || !idle_on) dout.ready <= 1'b1;
		else if ($urandom_range(99) < 5) dout.ready <= 1'b0;
		else dout.ready <= ($urandom_range(99) < 75);
	end

	// Compare each result word with the oldest expectation
	always @(posedge clk) begin
		result_t got, want;
		if (arst_n && dout.valid && dout.ready) begin
			got = '{dout.corrected, dout.segment_used, dout.coefficients_defaulted,
				dout.saturated};
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result word %h", got);
			end else begin
				want = expected_q.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h/%0d/%0d/%0d got %h/%0d/%0d/%0d",
							want.corrected, want.segment_used, want.coefficients_defaulted,
							want.saturated, got.corrected, got.segment_used,
							got.coefficients_defaulted, got.saturated);
				end
			end
		end
	end

	initial begin
		#20_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		int waited;
		din.valid = 1'b0;
		din.cmd = CMD_ERR;
		din.channel = '0;
		din.value = '0;
		din.table_select = '0;
		din.segment_select = 1'b0;
		din.gain_word = '0;
		din.offset_word = '0;
		foreach (coef_store[i]) coef_store[i] = '0;
		thr_lo = '0;
		thr_hi = '0;
		out_scale = 32'd65536;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_scales();
		test_thresholds();
		test_random();

		@(negedge clk);
		din.valid <= 1'b0;
		waited = 0;
		while (expected_q.size() != 0 && waited < 100000) begin
			@(negedge clk);
			waited++;
		end
		repeat (DRAIN) @(negedge clk);
		if (mismatches == 0 && expected_q.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
